// ===== rtl/pfsc_pkg.sv =====
// package with format codes, operation codes and float constants for the sample converter
`timescale 1ns / 1ps
`default_nettype none
package pfsc_pkg;
    localparam logic [1:0] FMT_FLOAT32 = 2'd0;
    localparam logic [1:0] FMT_INT32   = 2'd1;
    localparam logic [1:0] FMT_INT24   = 2'd2;
    localparam logic [1:0] FMT_INT16   = 2'd3;
    localparam logic OP_TO_FLOAT   = 1'b0;
    localparam logic OP_FROM_FLOAT = 1'b1;
    localparam logic [31:0] F32_ONE = 32'h3F80_0000;
    localparam logic [31:0] F32_SIGN = 32'h8000_0000;
    localparam logic [31:0] F32_ABS = 32'h7FFF_FFFF;

    // input word held between the input register and the conversion logic
    typedef struct packed {
        logic        operation;
        logic [31:0] sample_word;
        logic        end_of_buffer;
    } t_in_word;
endpackage
`default_nettype wire

// ===== rtl/pfsc_convert.sv =====
// combinational conversion between pcm integer formats and float32 bits
`timescale 1ns / 1ps
`default_nettype none
module pfsc_convert
    import pfsc_pkg::*;
(
    input  wire logic [1:0]  i_format,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_word,
    output logic [31:0]      o_result
);
    logic [31:0] w;
    logic        neg_i;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [5:0]  nm1;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        rnd;
    logic [24:0] mant_r;
    logic [7:0]  ex;
    logic [31:0] to_f;
    logic [7:0]  fexp;
    logic [30:0] fabs;
    logic        fneg;
    logic [23:0] fm;
    logic [8:0]  lsh;
    logic [8:0]  shl;
    logic [8:0]  shr;
    logic [31:0] v;
    logic [31:0] vs;
    logic [31:0] mask;
    logic [31:0] from_i;
    logic [31:0] clampf;

    always_comb begin
        case (i_format)
            FMT_INT32: begin nm1 = 6'd31; mask = 32'hFFFF_FFFF; end
            FMT_INT24: begin nm1 = 6'd23; mask = 32'h00FF_FFFF; end
            default:   begin nm1 = 6'd15; mask = 32'h0000_FFFF; end
        endcase
        // sign-extend low n bits
        case (i_format)
            FMT_INT32: w = i_word;
            FMT_INT24: w = {{8{i_word[23]}}, i_word[23:0]};
            default:   w = {{16{i_word[15]}}, i_word[15:0]};
        endcase
        neg_i = w[31];
        mag = neg_i ? (32'd0 - w) : w;
        p = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (mag[k]) p = 5'(k);
        end
        norm = mag << (5'd31 - p);
        mant = norm[31:8];
        // round to nearest even on the dropped bits
        rnd = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
        mant_r = {1'b0, mant} + {24'd0, rnd};
        ex = 8'(8'd127 + {3'd0, p} - {2'd0, nm1});
        if (mant_r[24]) begin
            ex = ex + 8'd1;
        end
        to_f = (mag == 32'd0) ? 32'd0 :
            {neg_i, ex, (mant_r[24] ? mant_r[23:1] : mant_r[22:0])};

        fexp = i_word[30:23];
        fabs = i_word[30:0];
        fneg = i_word[31];
        fm = {(fexp != 8'd0), i_word[22:0]};
        // scale is exp + (n-1) - 150 with subnormal exp as 1; int32 can shift left
        lsh = {1'b0, (fexp == 8'd0) ? 8'd1 : fexp} + {3'd0, nm1};
        shl = lsh - 9'd150;
        shr = 9'd150 - lsh;
        if (lsh >= 9'd150) begin
            v = {8'd0, fm} << shl[4:0];
        end else begin
            v = (shr >= 9'd32) ? 32'd0 : ({8'd0, fm} >> shr[4:0]);
        end
        vs = fneg ? (32'd0 - v) : v;
        if (fexp == 8'hFF || fabs == 31'd0) begin
            from_i = 32'd0;
        end else if ({1'b0, fabs} >= F32_ONE) begin
            from_i = (fneg ? (32'd1 << nm1) : ((32'd1 << nm1) - 32'd1)) & mask;
        end else begin
            from_i = vs & mask;
        end

        if (fexp == 8'hFF) begin
            clampf = 32'd0;
        end else if ({1'b0, fabs} > F32_ONE) begin
            clampf = (i_word & F32_SIGN) | F32_ONE;
        end else begin
            clampf = i_word;
        end

        if (i_format == FMT_FLOAT32) begin
            o_result = (i_operation == OP_FROM_FLOAT) ? clampf : i_word;
        end else begin
            o_result = (i_operation == OP_FROM_FLOAT) ? from_i : to_f;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pcm_float_sample_converter.sv =====
// top level: input register, conversion logic and output register
// result path: input register, combinational conversion, then output register; an output stall holds both
// throughput: one word per cycle while downstream keeps i_ready high, set by the single-pass conversion stage
// both stages advance when downstream space frees, so no bubbles under flow
// reset: synchronous active-low; clears valid flags and format to float32
`timescale 1ns / 1ps
`default_nettype none
module pcm_float_sample_converter
    import pfsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_sample_format,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_sample_word,
    input  wire logic        i_end_of_buffer,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result_word,
    output logic             o_last_sample
);
    logic [1:0]  r_format;
    logic        r_in_vld;
    t_in_word    r_in;
    logic        r_out_vld;
    logic [31:0] r_out_word;
    logic        r_out_last;
    logic [31:0] conv;
    logic        adv_out;

    assign adv_out = !r_out_vld || i_ready;
    assign o_ready = !r_in_vld || adv_out;

    pfsc_convert u_conv (
        .i_format   (r_format),
        .i_operation(r_in.operation),
        .i_word     (r_in.sample_word),
        .o_result   (conv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format  <= FMT_FLOAT32;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_format <= i_cfg_sample_format;
            end
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (adv_out) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in <= '{operation: i_operation, sample_word: i_sample_word,
                      end_of_buffer: i_end_of_buffer};
        end
        if (adv_out && r_in_vld) begin
            r_out_word <= conv;
            r_out_last <= r_in.end_of_buffer;
        end
    end

    assign o_valid = r_out_vld;
    assign o_result_word = r_out_word;
    assign o_last_sample = r_out_last;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_ready |=> r_out_vld && $stable(r_out_word))
        else $error("result word changed under stall");
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv_out |=> r_out_vld)
        else $error("staged word lost");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv_out |=> r_in_vld && $stable(r_in))
        else $error("input stage overwritten");
`endif
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the pcm/float sample converter: directed and random words checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import pfsc_pkg::*;

    typedef struct packed {
        logic [31:0] result_word;
        logic        last_sample;
    } t_out_word;

    // predicted conversion results, oldest first
    class conv_scoreboard;
        t_out_word pending[$];
        int        errors;
        logic [1:0] fmt;

        function new();
            errors = 0;
            fmt = FMT_FLOAT32;
        endfunction

        function int width_of(logic [1:0] f);
            if (f == FMT_INT32) return 32;
            if (f == FMT_INT24) return 24;
            return 16;
        endfunction

        function logic [31:0] int_to_f32(logic [31:0] word, int n);
            logic [63:0] w;
            logic [63:0] mag;
            logic [63:0] mant;
            logic [63:0] rem;
            logic [63:0] half;
            logic        sgn;
            int          p;
            int          e;
            int          sh;
            w = {32'd0, word} & ((64'd1 << n) - 1);
            if (w == 0) return 32'd0;
            sgn = w[n-1];
            mag = sgn ? (64'd1 << n) - w : w;
            p = 0;
            while (p < 40 && (mag >> (p + 1)) != 0) p++;
            e = p - (n - 1);
            if (p <= 23) begin
                mant = mag << (23 - p);
            end else begin
                sh = p - 23;
                rem = mag & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                mant = mag >> sh;
                if (rem > half || (rem == half && mant[0])) mant++;
                if (mant >> 24) begin
                    mant = mant >> 1;
                    e++;
                end
            end
            return {sgn, 8'(e + 127), mant[22:0]};
        endfunction

        function logic [31:0] f32_to_int(logic [31:0] f, int n);
            logic [7:0]  ex;
            logic [63:0] mask;
            logic [63:0] half;
            logic [63:0] m;
            logic [63:0] v;
            int          sh;
            ex = f[30:23];
            mask = (64'd1 << n) - 1;
            half = 64'd1 << (n - 1);
            if (ex == 8'hFF || (f & F32_ABS) == 0) return 32'd0;
            if ((f & F32_ABS) >= F32_ONE) return 32'((f[31] ? half : half - 1) & mask);
            m = {41'd0, f[22:0]};
            if (ex != 0) m[23] = 1'b1;
            else ex = 8'd1;
            sh = int'(ex) - 150 + (n - 1);
            if (sh >= 0) v = m << sh;
            else if (-sh >= 40) v = 0;
            else v = m >> (-sh);
            if (f[31]) v = (64'd0 - v) & mask;
            return 32'(v & mask);
        endfunction

        function void note_input(logic op, logic [31:0] word, logic eob);
            t_out_word r;
            if (fmt == FMT_FLOAT32) begin
                if (op == OP_TO_FLOAT) r.result_word = word;
                else if (word[30:23] == 8'hFF) r.result_word = 32'd0;
                else if ((word & F32_ABS) > F32_ONE) r.result_word = (word & F32_SIGN) | F32_ONE;
                else r.result_word = word;
            end else if (op == OP_FROM_FLOAT) begin
                r.result_word = f32_to_int(word, width_of(fmt));
            end else begin
                r.result_word = int_to_f32(word, width_of(fmt));
            end
            r.last_sample = eob;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] res, logic last);
            t_out_word x;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", res));
                return;
            end
            x = pending.pop_front();
            if (res !== x.result_word)
                report_mismatch($sformatf("result_word %h, predicted %h", res, x.result_word));
            if (last !== x.last_sample)
                report_mismatch($sformatf("last_sample %b, predicted %b", last, x.last_sample));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_fmt;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [31:0] word;
    logic        eob;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] res;
    logic        last;

    conv_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    int sent = 0;

    pcm_float_sample_converter DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_sample_format(cfg_fmt),
        .i_valid(in_valid), .o_ready(in_ready), .i_operation(op), .i_sample_word(word),
        .i_end_of_buffer(eob), .o_valid(out_valid), .i_ready(out_ready),
        .o_result_word(res), .o_last_sample(last)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side: check on accept, then pick next ready
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(res, last);
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // valid stays up after accept until the next word, an idle cycle or a drain
    task automatic send_word(logic o, logic [31:0] w, logic e);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        word <= w;
        eob <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(o, w, e);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_format(logic [1:0] f);
        drain();
        cfg_we <= 1'b1;
        cfg_fmt <= f;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.fmt = f;
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom();
        case ($urandom_range(5))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[30:23] = 8'(126 - $urandom_range(30));
            3: f[30:0] = $urandom_range(2) == 0 ? F32_ONE[30:0] : f[30:0];
            default: f[30:23] = 8'(100 + $urandom_range(30));
        endcase
        return f;
    endfunction

    logic [31:0] corner[12] = '{32'h0, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h7F80_0000, 32'hFFC0_0001, 32'h0000_0001, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
        32'h4000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};

    initial begin
        logic [1:0] f;
        rst_n = 0; cfg_we = 0; cfg_fmt = FMT_FLOAT32; in_valid = 0;
        op = OP_TO_FLOAT; word = 0; eob = 0; out_ready = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed corners through every format, both directions
        for (int k = 0; k < 4; k++) begin
            set_format(2'(k));
            for (int i = 0; i < 12; i += 2) begin
                send_word(OP_TO_FLOAT, corner[i] ^ (k == 1 ? 32'h0 : 32'h0080_0000), i[1]);
                send_word(OP_FROM_FLOAT, corner[i+1], ~i[1]);
            end
        end
        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            send_idle = ph < 4 ? 30 : (ph < 8 ? 63 : 0);
            recv_idle = ph < 4 ? 63 : (ph < 8 ? 30 : 0);
            f = (ph % 4 == 3) ? 2'($urandom_range(3)) : 2'(ph % 4);
            set_format(f);
            for (int i = 0; i < 110; i++) begin
                if ($urandom_range(1))
                    send_word(OP_FROM_FLOAT, rand_float(), 1'($urandom_range(1)));
                else
                    send_word(OP_TO_FLOAT, $urandom(), 1'($urandom_range(1)));
                // hold off once until the pipe is empty
                if (i == 50) drain();
            end
        end
        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d words over all four formats, both directions,", sent);
        $display("with corners, non-finite and subnormal floats and random stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
